FILE: rtl/bpb_pkg.sv
// Package for the backend pool balancer: payload structs, operation,
// mode and register codes, and small helpers for weights and saturation.
// Used by the top module, bpb_evt and the testbench.
`default_nettype none

package bpb_pkg;

    localparam int MAX_BACKENDS_DEF = 8;
    localparam int CONN_BITS_DEF    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TABLE  = 3'd4;

    // balance modes (unused code acts as round robin)
    localparam logic [1:0] MODE_RR     = 2'd0;
    localparam logic [1:0] MODE_SMOOTH = 2'd1;
    localparam logic [1:0] MODE_LEAST  = 2'd2;

    // item operations
    localparam logic [2:0] FUNC_PICK  = 3'd0;
    localparam logic [2:0] FUNC_OK    = 3'd1;
    localparam logic [2:0] FUNC_FAIL  = 3'd2;
    localparam logic [2:0] FUNC_OPEN  = 3'd3;
    localparam logic [2:0] FUNC_CLOSE = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] backend_index;
    } t_bpb_in;

    typedef struct packed {
        logic        found;
        logic [2:0]  chosen_index;
        logic [7:0]  up_mask;
        logic [15:0] conn_count;
    } t_bpb_out;

    // control for the health / connection update unit
    typedef struct packed {
        logic [2:0] func;
        logic       up;
        logic [7:0] rise_count;
        logic [7:0] fall_count;
    } t_evt_ctl;

    function automatic logic [3:0] weight_of(input logic [31:0] tbl, input int unsigned idx);
        logic [3:0] w;
        w = 4'd0;
        if (idx < 8) begin
            w = tbl[4*idx +: 4];
        end
        return w;
    endfunction

    function automatic logic signed [7:0] sat8(input int v);
        logic signed [7:0] r;
        if (v > 127) begin
            r = 8'sd127;
        end else if (v < -128) begin
            r = -8'sd128;
        end else begin
            r = 8'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/backend_pool_balancer.sv
// Pick: IDLE accepts, NORM wraps a stale rotation pointer below n (n = backends
// in use; never in smooth mode), SCAN reads the n entries, DRAIN takes the last
// read, PCOMMIT registers the result once the output is free. Events: IDLE,
// EREAD, ECOMMIT; ignored items and picks with n = 0 skip to the commit state.
// Reset (synchronous, active low): all backends up, registers at defaults,
// RAM entries read as zero until written (per-entry valid flops, no clear pass).
`default_nettype none

module backend_pool_balancer #(
    parameter int MAX_BACKENDS = bpb_pkg::MAX_BACKENDS_DEF,
    parameter int CONN_BITS    = bpb_pkg::CONN_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire bpb_pkg::t_bpb_in                 i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output bpb_pkg::t_bpb_out                     o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [bpb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bpb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import bpb_pkg::*;

    localparam int IW = $clog2(MAX_BACKENDS);
    localparam int CW = $clog2(MAX_BACKENDS + 1);
    localparam int EW = CONN_BITS + 24;
    localparam int TW = $clog2(MAX_BACKENDS * 15 + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_NORM, S_SCAN, S_DRAIN, S_PCOMMIT, S_EREAD, S_ECOMMIT
    } t_state;

    // configuration
    logic [1:0]  r_mode;
    logic [3:0]  r_count;
    logic [7:0]  r_rise, r_fall;
    logic [31:0] r_weights;

    // state
    t_state                r_state;
    logic [MAX_BACKENDS-1:0] r_up, r_ent_ok;
    logic [IW-1:0]         r_next;
    logic [2:0]            r_func, r_chosen;
    logic [IW-1:0]         r_idx;
    logic                  r_ev_ok;
    logic [IW-1:0]         r_i, r_pidx, r_best;
    logic [CW-1:0]         r_k;
    logic                  r_pv, r_rd_ok, r_best_found;
    logic signed [7:0]     r_best_w;
    logic [EW-1:0]         r_best_ent;
    logic [TW-1:0]         r_total;
    logic                  r_out_valid;
    t_bpb_out              r_out;

    // comb
    logic [CW-1:0]         n_used, i_plus, b_plus;
    logic [IW-1:0]         n_i, n_best_next;
    logic                  is_smooth, is_least, out_free;
    logic                  rd_en, ram_we;
    logic [IW-1:0]         rd_addr, ram_waddr;
    logic [EW-1:0]         ram_wdata, ram_q, rd_entry;
    logic [CONN_BITS-1:0]  p_conns;
    logic signed [7:0]     p_dw, p_new_dw;
    logic [3:0]            p_w;
    logic                  p_up, p_take;
    logic [EW-1:0]         p_ent_new;
    logic [MAX_BACKENDS-1:0] n_up;
    logic [7:0]            mask;
    t_evt_ctl              evt_ctl;
    logic                  evt_up;
    logic [EW-1:0]         evt_entry;

    assign is_smooth = (r_mode == MODE_SMOOTH);
    assign is_least  = (r_mode == MODE_LEAST);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        if (int'(r_count) > MAX_BACKENDS) begin
            n_used = CW'(MAX_BACKENDS);
        end else begin
            n_used = CW'(r_count);
        end
    end

    // rotation with wrap at n
    assign i_plus      = CW'(r_i) + CW'(1);
    assign n_i         = (i_plus >= n_used) ? '0 : IW'(i_plus);
    assign b_plus      = CW'(r_best) + CW'(1);
    assign n_best_next = (b_plus >= n_used) ? '0 : IW'(b_plus);

    assign rd_entry = r_rd_ok ? ram_q : '0;

    // scan processing of the entry read last cycle
    always_comb begin
        p_conns   = rd_entry[EW-1:24];
        p_dw      = rd_entry[23:16];
        p_w       = weight_of(r_weights, int'(r_pidx));
        p_up      = r_up[r_pidx];
        p_new_dw  = sat8(int'(p_dw) + int'(p_w));
        p_ent_new = {p_conns, p_new_dw, rd_entry[15:0]};
        if (is_smooth) begin
            p_take = p_up && (!r_best_found || (p_new_dw > r_best_w));
        end else if (is_least) begin
            p_take = p_up && (!r_best_found || (p_conns < r_best_ent[EW-1:24]));
        end else begin
            p_take = p_up && !r_best_found;
        end
    end

    always_comb begin
        evt_ctl.func       = r_func;
        evt_ctl.up         = r_up[r_idx];
        evt_ctl.rise_count = r_rise;
        evt_ctl.fall_count = r_fall;
    end

    bpb_evt #(
        .CONN_BITS (CONN_BITS)
    ) u_evt (
        .i_ctl   (evt_ctl),
        .i_entry (rd_entry),
        .o_up    (evt_up),
        .o_entry (evt_entry)
    );

    // RAM port control
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_i;
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = p_ent_new;
        n_up      = r_up;
        case (r_state)
            S_SCAN: begin
                rd_en = 1'b1;
                if (r_pv && is_smooth && p_up) begin
                    ram_we = 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_pv && is_smooth && p_up) begin
                    ram_we = 1'b1;
                end
            end
            S_PCOMMIT: begin
                ram_waddr = r_best;
                ram_wdata = {r_best_ent[EW-1:24],
                             sat8(int'(r_best_w) - int'(r_total)),
                             r_best_ent[15:0]};
                ram_we    = out_free && is_smooth && r_best_found;
            end
            S_EREAD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
            end
            S_ECOMMIT: begin
                ram_waddr = r_idx;
                ram_wdata = evt_entry;
                if (out_free && r_ev_ok) begin
                    ram_we       = 1'b1;
                    n_up[r_idx]  = evt_up;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mask = 8'd0;
        for (int b = 0; b < 8; b++) begin
            if (b < MAX_BACKENDS && b < int'(n_used)) begin
                mask[b] = n_up[b];
            end
        end
    end

    bpb_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BACKENDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RR;
            r_count   <= 4'd8;
            r_rise    <= 8'd2;
            r_fall    <= 8'd3;
            r_weights <= 32'h1111_1111;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BALANCE_MODE:  r_mode    <= i_cfg_wdata[1:0];
                CFG_BACKEND_COUNT: r_count   <= i_cfg_wdata[3:0];
                CFG_RISE_COUNT:    r_rise    <= i_cfg_wdata[7:0];
                CFG_FALL_COUNT:    r_fall    <= i_cfg_wdata[7:0];
                CFG_WEIGHT_TABLE:  r_weights <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_up         <= '1;
            r_ent_ok     <= '0;
            r_next       <= '0;
            r_pv         <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (ram_we) begin
                r_ent_ok[ram_waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_ent_ok[rd_addr];
            end
            // commit states load the next result themselves
            if (r_out_valid && i_out_ready
                && r_state != S_PCOMMIT && r_state != S_ECOMMIT) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_SCAN || r_state == S_DRAIN) && r_pv) begin
                if (is_smooth && p_up) begin
                    r_total <= r_total + TW'(p_w);
                end
                if (p_take) begin
                    r_best_found <= 1'b1;
                    r_best       <= r_pidx;
                    r_best_w     <= p_new_dw;
                    r_best_ent   <= is_smooth ? p_ent_new : rd_entry;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func <= i_in.func;
                        r_idx  <= IW'(i_in.backend_index);
                        if (i_in.func == FUNC_PICK) begin
                            r_best_found <= 1'b0;
                            r_total      <= '0;
                            r_pv         <= 1'b0;
                            r_k          <= '0;
                            r_i          <= is_smooth ? '0 : r_next;
                            r_state      <= (n_used == '0) ? S_PCOMMIT : S_NORM;
                        end else begin
                            r_chosen <= (i_in.func <= FUNC_CLOSE) ? i_in.backend_index : 3'd0;
                            if (i_in.func <= FUNC_CLOSE
                                && int'(i_in.backend_index) < int'(n_used)) begin
                                r_ev_ok <= 1'b1;
                                r_state <= S_EREAD;
                            end else begin
                                r_ev_ok <= 1'b0;
                                r_state <= S_ECOMMIT;
                            end
                        end
                    end
                end
                S_NORM: begin
                    // stale pointer after backend_count shrinks
                    if (CW'(r_i) >= n_used) begin
                        r_i <= IW'(CW'(r_i) - n_used);
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv   <= 1'b1;
                    r_pidx <= r_i;
                    r_i    <= n_i;
                    r_k    <= r_k + CW'(1);
                    if (r_k == n_used - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_pv    <= 1'b0;
                    r_state <= S_PCOMMIT;
                end
                S_PCOMMIT: begin
                    if (out_free) begin
                        if (r_best_found && !is_smooth) begin
                            r_next <= n_best_next;
                        end
                        r_out_valid        <= 1'b1;
                        r_out.found        <= r_best_found;
                        r_out.chosen_index <= r_best_found ? 3'(r_best) : 3'd0;
                        r_out.up_mask      <= mask;
                        r_out.conn_count   <= r_best_found ?
                                              16'(r_best_ent[EW-1:24]) : 16'd0;
                        r_state            <= S_IDLE;
                    end
                end
                S_EREAD: begin
                    r_state <= S_ECOMMIT;
                end
                S_ECOMMIT: begin
                    if (out_free) begin
                        r_up               <= n_up;
                        r_out_valid        <= 1'b1;
                        r_out.found        <= r_ev_ok;
                        r_out.chosen_index <= r_chosen;
                        r_out.up_mask      <= mask;
                        r_out.conn_count   <= r_ev_ok ?
                                              16'(evt_entry[EW-1:24]) : 16'd0;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && rd_en) |-> (ram_waddr != rd_addr))
        else $error("read and write of the same entry in one cycle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k < n_used))
        else $error("scan ran past the backends in use");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            ($past(r_state) == S_PCOMMIT || $past(r_state) == S_ECOMMIT))
        else $error("result appeared outside a commit state");

endmodule

`default_nettype wire

FILE: rtl/bpb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module bpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

FILE: rtl/bpb_evt.sv
// Health and connection update for one backend entry: rise/fall rules
// and saturating connection count. Depends on bpb_pkg.
`default_nettype none

module bpb_evt #(
    parameter int CONN_BITS = bpb_pkg::CONN_BITS_DEF
) (
    input  wire bpb_pkg::t_evt_ctl      i_ctl,
    input  wire logic [CONN_BITS+23:0]  i_entry,
    output logic                        o_up,
    output logic      [CONN_BITS+23:0]  o_entry
);
    import bpb_pkg::*;

    // entry layout: conns | dyn_weight | success_run | fail_run
    logic [7:0]           fail_in, succ_in, dw_in;
    logic [CONN_BITS-1:0] conn_in;
    logic [7:0]           fail_nx, succ_nx, dw_nx, run_inc;
    logic [CONN_BITS-1:0] conn_nx;
    logic                 up_nx;

    assign fail_in = i_entry[7:0];
    assign succ_in = i_entry[15:8];
    assign dw_in   = i_entry[23:16];
    assign conn_in = i_entry[CONN_BITS+23:24];

    always_comb begin
        fail_nx = fail_in;
        succ_nx = succ_in;
        dw_nx   = dw_in;
        conn_nx = conn_in;
        up_nx   = i_ctl.up;
        run_inc = 8'd0;
        case (i_ctl.func)
            FUNC_OK: begin
                fail_nx = 8'd0;
                if (!i_ctl.up) begin
                    run_inc = (succ_in == 8'hFF) ? succ_in : succ_in + 8'd1;
                    if (run_inc >= i_ctl.rise_count) begin
                        up_nx   = 1'b1;
                        succ_nx = 8'd0;
                        dw_nx   = 8'd0;
                    end else begin
                        succ_nx = run_inc;
                    end
                end
            end
            FUNC_FAIL: begin
                succ_nx = 8'd0;
                if (i_ctl.up) begin
                    run_inc = (fail_in == 8'hFF) ? fail_in : fail_in + 8'd1;
                    if (run_inc >= i_ctl.fall_count) begin
                        up_nx   = 1'b0;
                        fail_nx = 8'd0;
                    end else begin
                        fail_nx = run_inc;
                    end
                end
            end
            FUNC_OPEN: begin
                if (conn_in != {CONN_BITS{1'b1}}) begin
                    conn_nx = conn_in + CONN_BITS'(1);
                end
            end
            FUNC_CLOSE: begin
                if (conn_in != '0) begin
                    conn_nx = conn_in - CONN_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_up    = up_nx;
    assign o_entry = {conn_nx, dw_nx, succ_nx, fail_nx};

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for backend_pool_balancer: directed and random items
// with random idling on both sides, checked against a scoreboard-side predictor.
// Depends on bpb_pkg and the backend_pool_balancer RTL.
`timescale 1ns / 100ps

module testbench;

    import bpb_pkg::*;

    // Predicts each result from its own copy of the registers and backend table.
    class bpb_scoreboard;
        bit [1:0]         bal_mode;
        bit [3:0]         n_cfg;
        bit [7:0]         rise_n;
        bit [7:0]         fall_n;
        bit [31:0]        wtab;

        bit               up [8];
        bit [7:0]         fail_run [8];
        bit [7:0]         ok_run [8];
        bit [15:0]        conns [8];
        bit signed [7:0]  dyn_w [8];
        bit [2:0]         rot;

        t_bpb_out         pending [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      n_items;
        int unsigned      n_picks;
        int unsigned      n_served;
        int unsigned      n_events;
        int unsigned      n_ignored;
        int unsigned      useful;
        bit               last_found;
        bit [2:0]         last_chosen;

        function new();
            bal_mode = MODE_RR;
            n_cfg    = 4'd8;
            rise_n   = 8'd2;
            fall_n   = 8'd3;
            wtab     = 32'h1111_1111;
            for (int i = 0; i < 8; i++) begin
                up[i]       = 1'b1;
                fail_run[i] = '0;
                ok_run[i]   = '0;
                conns[i]    = '0;
                dyn_w[i]    = '0;
            end
            rot = '0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [31:0] data);
            case (idx)
                CFG_BALANCE_MODE:  bal_mode = data[1:0];
                CFG_BACKEND_COUNT: n_cfg    = data[3:0];
                CFG_RISE_COUNT:    rise_n   = data[7:0];
                CFG_FALL_COUNT:    fall_n   = data[7:0];
                CFG_WEIGHT_TABLE:  wtab     = data;
                default: ;
            endcase
        endfunction

        function int active();
            return (n_cfg > 8) ? 8 : int'(n_cfg);
        endfunction

        function int weight(input int i);
            return int'(wtab[4*i +: 4]);
        endfunction

        function bit signed [7:0] clamp_s8(input int v);
            if (v > 127) return 8'sd127;
            if (v < -128) return -8'sd128;
            return 8'(v);
        endfunction

        function int rr_pick(input int n);
            int k;
            int i;
            for (k = 0; k < n; k++) begin
                i = (int'(rot) + k) % n;
                if (up[i]) begin
                    rot = 3'((i + 1) % n);
                    return i;
                end
            end
            return -1;
        endfunction

        function int smooth_pick(input int n);
            int best;
            int total;
            int i;
            best  = -1;
            total = 0;
            for (i = 0; i < n; i++) begin
                if (!up[i]) continue;
                dyn_w[i] = clamp_s8(int'(dyn_w[i]) + weight(i));
                total += weight(i);
                if (best < 0 || dyn_w[i] > dyn_w[best]) best = i;
            end
            if (best >= 0) dyn_w[best] = clamp_s8(int'(dyn_w[best]) - total);
            return best;
        endfunction

        function int least_pick(input int n);
            int best;
            int k;
            int i;
            best = -1;
            for (k = 0; k < n; k++) begin
                i = (int'(rot) + k) % n;
                if (!up[i]) continue;
                if (best < 0 || conns[i] < conns[best]) best = i;
            end
            if (best >= 0) rot = 3'((best + 1) % n);
            return best;
        endfunction

        function void note_item(input t_bpb_in it);
            t_bpb_out e;
            int n;
            int b;
            int x;
            e = '0;
            n = active();
            x = int'(it.backend_index);
            n_items++;
            case (it.func)
                FUNC_PICK: begin
                    b = -1;
                    n_picks++;
                    if (n > 0) begin
                        case (bal_mode)
                            MODE_SMOOTH: b = smooth_pick(n);
                            MODE_LEAST:  b = least_pick(n);
                            default:     b = rr_pick(n);
                        endcase
                    end
                    if (b >= 0) begin
                        e.found        = 1'b1;
                        e.chosen_index = 3'(b);
                        e.conn_count   = conns[b];
                        n_served++;
                    end
                    last_found  = e.found;
                    last_chosen = e.chosen_index;
                end
                FUNC_OK, FUNC_FAIL, FUNC_OPEN, FUNC_CLOSE: begin
                    e.chosen_index = it.backend_index;
                    if (x < n) begin
                        e.found = 1'b1;
                        case (it.func)
                            FUNC_OK: begin
                                fail_run[x] = '0;
                                if (!up[x]) begin
                                    if (ok_run[x] != 8'hff) ok_run[x]++;
                                    if (ok_run[x] >= rise_n) begin
                                        up[x]     = 1'b1;
                                        ok_run[x] = '0;
                                        dyn_w[x]  = '0;
                                    end
                                end
                            end
                            FUNC_FAIL: begin
                                ok_run[x] = '0;
                                if (up[x]) begin
                                    if (fail_run[x] != 8'hff) fail_run[x]++;
                                    if (fail_run[x] >= fall_n) begin
                                        up[x]       = 1'b0;
                                        fail_run[x] = '0;
                                    end
                                end
                            end
                            FUNC_OPEN:  if (conns[x] != 16'hffff) conns[x]++;
                            default:    if (conns[x] != 16'h0) conns[x]--;
                        endcase
                        e.conn_count = conns[x];
                        n_events++;
                    end else begin
                        n_ignored++;
                    end
                end
                default: n_ignored++;
            endcase
            for (int i = 0; i < n; i++) e.up_mask[i] = up[i];
            if (it.func == FUNC_PICK || e.found) useful++;
            pending.push_back(e);
        endfunction

        function void check_result(input t_bpb_out got);
            t_bpb_out e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: found=%0d chosen=%0d mask=%02h conns=%0d",
                             got.found, got.chosen_index, got.up_mask, got.conn_count);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.found !== e.found || got.chosen_index !== e.chosen_index ||
                got.up_mask !== e.up_mask || got.conn_count !== e.conn_count) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d mismatch: exp found=%0d chosen=%0d mask=%02h conns=%0d",
                             checked, e.found, e.chosen_index, e.up_mask, e.conn_count);
                    $display("                     got found=%0d chosen=%0d mask=%02h conns=%0d",
                             got.found, got.chosen_index, got.up_mask, got.conn_count);
                end
            end
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_bpb_in          in_item = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_bpb_out         out_item;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [31:0]      cfg_wdata = '0;

    bpb_scoreboard    sb = new();
    bit               no_idle = 1'b0;
    bit               hold_off = 1'b0;
    bit               pressure_go = 1'b0;
    int unsigned      ready_stall = 0;
    int unsigned      settings = 0;

    backend_pool_balancer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check accepted items, then pick the next ready value
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
        if (hold_off) begin
            out_ready <= 1'b0;
        end else if (ready_stall > 0) begin
            out_ready <= 1'b0;
            ready_stall--;
        end else begin
            out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) ready_stall = gap_len();
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(input logic [2:0] func, input logic [2:0] idx);
        t_bpb_in     it;
        int unsigned gap;
        it.func          = func;
        it.backend_index = idx;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(it);
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // registers change only with nothing in flight
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (!sb.drained()) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(input logic [1:0] bal_mode, input logic [3:0] n_backends,
                                input logic [7:0] rise_n, input logic [7:0] fall_n,
                                input logic [31:0] weights);
        cfg_write(CFG_BALANCE_MODE, 32'(bal_mode));
        cfg_write(CFG_BACKEND_COUNT, 32'(n_backends));
        cfg_write(CFG_RISE_COUNT, 32'(rise_n));
        cfg_write(CFG_FALL_COUNT, 32'(fall_n));
        cfg_write(CFG_WEIGHT_TABLE, weights);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // traffic shaped like real use: picks, picks followed by a connection or
    // a failure on the chosen backend, health report runs, closes, and noise
    task automatic run_random(input int unsigned target);
        int unsigned goal;
        int unsigned kind;
        int unsigned k;
        int          n;
        logic [2:0]  b;
        goal = sb.useful + target;
        while (sb.useful < goal) begin
            n    = sb.active();
            kind = $urandom_range(0, 99);
            k    = $urandom_range(1, 5);
            b    = (n > 0) ? 3'($urandom_range(0, n - 1)) : 3'($urandom_range(0, 7));
            if (kind < 28) begin
                repeat ($urandom_range(1, 4)) send_item(FUNC_PICK, 3'($urandom_range(0, 7)));
            end else if (kind < 42) begin
                send_item(FUNC_PICK, 3'($urandom_range(0, 7)));
                if (sb.last_found) send_item(FUNC_OPEN, sb.last_chosen);
            end else if (kind < 56) begin
                repeat (k) send_item(FUNC_FAIL, b);
            end else if (kind < 68) begin
                repeat (k) send_item(FUNC_OK, b);
            end else if (kind < 80) begin
                send_item(FUNC_PICK, 3'($urandom_range(0, 7)));
                if (sb.last_found) send_item(FUNC_FAIL, sb.last_chosen);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 3)) send_item(FUNC_CLOSE, b);
            end else begin
                send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        int unsigned w;
        logic [1:0]  m;
        logic [3:0]  nb;
        logic [7:0]  rs;
        logic [7:0]  fl;
        logic [31:0] wt;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: round robin over 8, rise 2, fall 3
        send_item(FUNC_PICK, 3'd0);
        send_item(FUNC_PICK, 3'd7);
        send_item(FUNC_OPEN, 3'd7);
        send_item(FUNC_CLOSE, 3'd7);
        send_item(FUNC_CLOSE, 3'd7);     // already at zero
        repeat (3) send_item(FUNC_FAIL, 3'd2);
        send_item(FUNC_PICK, 3'd0);      // skips the down backend
        repeat (2) send_item(FUNC_OK, 3'd2);
        send_item(3'd5, 3'd7);
        send_item(3'd7, 3'd0);

        // unused mode code, pointer left past the shrunken count, zero thresholds
        wait_idle();
        apply_config(2'd3, 4'd3, 8'd0, 8'd0, 32'hffff_ffff);
        send_item(FUNC_PICK, 3'd0);
        send_item(FUNC_FAIL, 3'd0);
        send_item(FUNC_PICK, 3'd0);
        send_item(FUNC_OK, 3'd0);
        send_item(FUNC_OPEN, 3'd5);      // beyond count, ignored

        wait_idle();
        apply_config(MODE_SMOOTH, 4'd15, 8'd255, 8'd255, 32'h89ab_cdef);
        repeat (3) send_item(FUNC_PICK, 3'd0);

        wait_idle();
        apply_config(MODE_LEAST, 4'd0, 8'd1, 8'd1, 32'h0);
        send_item(FUNC_PICK, 3'd0);
        send_item(FUNC_OPEN, 3'd0);
        send_item(3'd6, 3'd6);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            m  = 2'(p % 4);
            nb = 4'($urandom_range(2, 8));
            rs = 8'($urandom_range(0, 3));
            fl = 8'($urandom_range(0, 3));
            wt = $urandom();
            case (p)
                1: begin nb = 4'd15; fl = 8'd0; wt = 32'hffff_ffff; end
                2: begin nb = 4'd1; wt = 32'h0; end
                4: begin rs = 8'd255; fl = 8'd255; end
                6: nb = 4'd9;
                default: ;
            endcase
            apply_config(m, nb, rs, fl, wt);
            no_idle = (p == 5);
            if (p == 3) pressure_go = 1'b1;
            run_random(70);
        end

        // back-to-back connection counting on one backend
        wait_idle();
        apply_config(MODE_LEAST, 4'd8, 8'd1, 8'd1, $urandom());
        no_idle = 1'b1;
        repeat (4) send_item(FUNC_OPEN, 3'd3);
        repeat (2) send_item(FUNC_CLOSE, 3'd3);
        send_item(FUNC_PICK, 3'd0);
        in_valid <= 1'b0;

        w = 0;
        while (!sb.drained() && w < 20000) begin
            @(posedge clk);
            w++;
        end
        repeat (30) @(posedge clk);

        $display("Run covered %0d items: %0d picks (%0d served), %0d events taken, %0d ignored,",
                 sb.n_items, sb.n_picks, sb.n_served, sb.n_events, sb.n_ignored);
        $display("over %0d register settings; %0d results compared, %0d mismatches.",
                 settings, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.drained()) begin
            $display("Verification passed");
        end else begin
            if (!sb.drained()) $display("%0d expected results never arrived", sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bpb_pkg.sv
rtl/bpb_ram.sv
rtl/bpb_evt.sv
rtl/backend_pool_balancer.sv
tb/testbench.sv
